### rtl/ldc_pkg.sv
package ldc_pkg;

  // Sizes of the classifier.
  localparam int MAX_BANDS   = 8;
  localparam int MAX_CLASSES = 16;
  localparam int BAND_IW     = $clog2(MAX_BANDS);

  // Field widths.
  localparam int PIX_W   = 16;
  localparam int WGT_W   = 16;
  localparam int VAL_W   = 35;
  localparam int PROD_W  = WGT_W + PIX_W + 1;
  localparam int DIST_W  = VAL_W + 1;
  localparam int MODE_W  = 2;
  localparam int SLOT_W  = 4;
  localparam int CLS_W   = 4;
  localparam int BCNT_W  = 4;
  localparam int CCNT_W  = 5;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Minimum search: groups of candidates reduced in the first merge stage.
  localparam int GRP  = 4;
  localparam int NGRP = MAX_CLASSES / GRP;

  // Pipeline stages from the input register through the last merge stage.
  localparam int STAGES = 8;

  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_CLASSIFY    = 2'd0;
  localparam mode_t MODE_LOAD_WEIGHT = 2'd1;
  localparam mode_t MODE_LOAD_CENTRE = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_BAND_COUNT  = 1'd0;
  localparam cfg_idx_t REG_CLASS_COUNT = 1'd1;

  // One class candidate: its distance to the projection and its index.
  typedef struct packed {
    logic              vld;
    logic [DIST_W-1:0] distance;
    logic [CLS_W-1:0]  id;
  } cand_t;

  // Keep a unless b is valid and strictly nearer, so ties go to the lower index.
  function automatic cand_t pick(cand_t a, cand_t b);
    cand_t r;
    r = (b.vld && (!a.vld || (b.distance < a.distance))) ? b : a;
    return r;
  endfunction

endpackage

### rtl/ldc_in_if.sv
interface ldc_in_if;
  logic                                valid;
  logic                                ready;
  logic [ldc_pkg::MODE_W-1:0]          mode;
  logic [ldc_pkg::SLOT_W-1:0]          slot;
  logic signed [ldc_pkg::VAL_W-1:0]    load_value;
  logic [ldc_pkg::PIX_W-1:0]           band0;
  logic [ldc_pkg::PIX_W-1:0]           band1;
  logic [ldc_pkg::PIX_W-1:0]           band2;
  logic [ldc_pkg::PIX_W-1:0]           band3;
  logic [ldc_pkg::PIX_W-1:0]           band4;
  logic [ldc_pkg::PIX_W-1:0]           band5;
  logic [ldc_pkg::PIX_W-1:0]           band6;
  logic [ldc_pkg::PIX_W-1:0]           band7;

  modport source (
    output valid, mode, slot, load_value,
    output band0, band1, band2, band3, band4, band5, band6, band7,
    input  ready
  );

  modport sink (
    input  valid, mode, slot, load_value,
    input  band0, band1, band2, band3, band4, band5, band6, band7,
    output ready
  );
endinterface

### rtl/ldc_out_if.sv
interface ldc_out_if;
  logic                             valid;
  logic                             ready;
  logic [ldc_pkg::CLS_W-1:0]        class_id;
  logic signed [ldc_pkg::VAL_W-1:0] projected_value;

  modport source (output valid, class_id, projected_value, input ready);
  modport sink (input valid, class_id, projected_value, output ready);
endinterface

### rtl/ldc_mul_lane.sv
module ldc_mul_lane (
  input  logic                              clk_i,
  input  logic signed [ldc_pkg::WGT_W-1:0]  weight_i,
  input  logic [ldc_pkg::PIX_W-1:0]         pix_i,
  output logic signed [ldc_pkg::PROD_W-1:0] prod_o
);

  logic signed [ldc_pkg::PROD_W-1:0] prod_d;
  logic signed [ldc_pkg::PROD_W-1:0] prod_q;

  // Signed weight times the band value, taken as a positive number.
  assign prod_d = weight_i * $signed({1'b0, pix_i});

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

### rtl/ldc_sum_tree.sv
module ldc_sum_tree (
  input  logic                              clk_i,
  input  logic signed [ldc_pkg::PROD_W-1:0] prod_i [ldc_pkg::MAX_BANDS],
  output logic signed [ldc_pkg::VAL_W-1:0]  sum_o
);

  localparam int VW = ldc_pkg::VAL_W;
  localparam int PW = ldc_pkg::PROD_W;
  localparam int NB = ldc_pkg::MAX_BANDS;

  logic signed [VW-1:0] pair_d [NB/2];
  logic signed [VW-1:0] pair_q [NB/2];
  logic signed [VW-1:0] quad_d [NB/4];
  logic signed [VW-1:0] quad_q [NB/4];
  logic signed [VW-1:0] sum_d;
  logic signed [VW-1:0] sum_q;

  // First level: neighboring products, sign extended to the result width.
  always_comb begin
    for (int i = 0; i < NB/2; i++) begin
      pair_d[i] = $signed({{(VW-PW){prod_i[2*i][PW-1]}}, prod_i[2*i]})
                + $signed({{(VW-PW){prod_i[2*i+1][PW-1]}}, prod_i[2*i+1]});
    end
  end

  // Second level: pairs of pairs.
  always_comb begin
    for (int i = 0; i < NB/4; i++) begin
      quad_d[i] = pair_q[2*i] + pair_q[2*i+1];
    end
  end

  // Last level: the whole dot product. The sum is exact in the result width.
  assign sum_d = quad_q[0] + quad_q[1];

  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
    quad_q <= quad_d;
    sum_q  <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

### rtl/ldc_dist_lane.sv
module ldc_dist_lane (
  input  logic                             clk_i,
  input  logic signed [ldc_pkg::VAL_W-1:0] proj_i,
  input  logic signed [ldc_pkg::VAL_W-1:0] centre_i,
  input  logic                             use_i,
  input  logic [ldc_pkg::CLS_W-1:0]        id_i,
  output ldc_pkg::cand_t                   cand_o
);

  localparam int VW = ldc_pkg::VAL_W;
  localparam int DW = ldc_pkg::DIST_W;

  logic signed [DW-1:0] diff;
  logic [DW-1:0]        mag;
  ldc_pkg::cand_t       cand_q;

  // One bit wider than the operands, so the difference and its magnitude fit.
  assign diff = $signed({proj_i[VW-1], proj_i}) - $signed({centre_i[VW-1], centre_i});
  assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);

  always_ff @(posedge clk_i) begin
    cand_q.vld      <= use_i;
    cand_q.distance <= mag;
    cand_q.id       <= id_i;
  end

  assign cand_o = cand_q;

endmodule

### rtl/ldc_min_merge.sv
module ldc_min_merge (
  input  logic                      clk_i,
  input  ldc_pkg::cand_t            cand_i [ldc_pkg::MAX_CLASSES],
  input  logic                      en_i,
  output logic [ldc_pkg::CLS_W-1:0] class_id_o
);

  localparam int GRP  = ldc_pkg::GRP;
  localparam int NGRP = ldc_pkg::NGRP;

  ldc_pkg::cand_t grp_d [NGRP];
  ldc_pkg::cand_t grp_q [NGRP];
  ldc_pkg::cand_t best_d;
  ldc_pkg::cand_t best_q;

  // First stage: the nearest candidate in each group, scanned in index order.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = cand_i[g*GRP];
      for (int k = 1; k < GRP; k++) begin
        grp_d[g] = ldc_pkg::pick(grp_d[g], cand_i[g*GRP+k]);
      end
    end
  end

  // Second stage: the nearest of the group winners. With no valid candidate
  // the first entry stays, which carries index zero.
  always_comb begin
    best_d = grp_q[0];
    for (int g = 1; g < NGRP; g++) begin
      best_d = ldc_pkg::pick(best_d, grp_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    if (en_i) begin
      best_q <= best_d;
    end
  end

  assign class_id_o = best_q.id;

endmodule

### rtl/linear_discriminant_pixel_classifier_top.sv
// Linear discriminant pixel classifier. A classify word projects the pixel's
// bands onto the stored Q1.15 weights and returns the index of the nearest
// stored class centre, lowest index on a tie, together with the projection.
// Load words write one weight or one centre. A classify word runs through an
// eight-stage pipeline (the input register, band multiplier lanes, a
// three-level adder tree, class distance lanes and a two-stage minimum
// merge), and the input stays not ready while it is in flight. Its result
// is loaded into the output register when that register is free, and the
// next word may be accepted while the result waits there. Configuration
// must be written by the user only while the block is idle; the block
// itself does not enforce it.
module linear_discriminant_pixel_classifier_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ldc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ldc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  ldc_in_if.sink                             pix_i,
  ldc_out_if.source                          res_o
);

  localparam int NB  = ldc_pkg::MAX_BANDS;
  localparam int NC  = ldc_pkg::MAX_CLASSES;
  localparam int VW  = ldc_pkg::VAL_W;
  localparam int WW  = ldc_pkg::WGT_W;
  localparam int PXW = ldc_pkg::PIX_W;
  localparam int NS  = ldc_pkg::STAGES;

  logic [ldc_pkg::BCNT_W-1:0]   band_count_q;
  logic [ldc_pkg::CCNT_W-1:0]   class_count_q;
  logic signed [WW-1:0]         weight_q [NB];
  logic signed [VW-1:0]         centre_q [NC];
  logic [NS-1:0]                vld_q, vld_d;
  logic [PXW-1:0]               band     [NB];
  logic [PXW-1:0]               pix_q    [NB];
  logic [NC-1:0]                cls_use_q;
  logic signed [ldc_pkg::PROD_W-1:0] prod [NB];
  logic signed [VW-1:0]         proj;
  logic signed [VW-1:0]         proj5_q, proj6_q, proj7_q;
  ldc_pkg::cand_t               cand [NC];
  logic [ldc_pkg::CLS_W-1:0]    best_id;
  logic                         accept;
  logic                         is_classify;
  logic                         out_load;
  logic                         stage7_en;
  logic                         out_vld_q, out_vld_d;
  logic [ldc_pkg::CLS_W-1:0]    out_id_q;
  logic signed [VW-1:0]         out_proj_q;

  // Input handshake: one classify word in flight at a time.
  assign pix_i.ready = ~|vld_q;
  assign accept      = pix_i.valid && pix_i.ready;
  assign is_classify = (pix_i.mode == ldc_pkg::MODE_CLASSIFY);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_count_q  <= ldc_pkg::BCNT_W'(8);
      class_count_q <= ldc_pkg::CCNT_W'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ldc_pkg::REG_BAND_COUNT:  band_count_q  <= cfg_data_i[ldc_pkg::BCNT_W-1:0];
        ldc_pkg::REG_CLASS_COUNT: class_count_q <= cfg_data_i[ldc_pkg::CCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Projection weights, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NB; i++) begin
        weight_q[i] <= '0;
      end
    end else if (accept && (pix_i.mode == ldc_pkg::MODE_LOAD_WEIGHT)
                 && (32'(pix_i.slot) < NB)) begin
      weight_q[pix_i.slot[ldc_pkg::BAND_IW-1:0]] <= pix_i.load_value[WW-1:0];
    end
  end

  // Class centres hold whatever was last written.
  always_ff @(posedge clk_i) begin
    if (accept && (pix_i.mode == ldc_pkg::MODE_LOAD_CENTRE) && (32'(pix_i.slot) < NC)) begin
      centre_q[pix_i.slot] <= pix_i.load_value;
    end
  end

  // Band fields as an array.
  always_comb begin
    band[0] = pix_i.band0;
    band[1] = pix_i.band1;
    band[2] = pix_i.band2;
    band[3] = pix_i.band3;
    band[4] = pix_i.band4;
    band[5] = pix_i.band5;
    band[6] = pix_i.band6;
    band[7] = pix_i.band7;
  end

  // Input register: unused bands become zero, unused classes are marked.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < NB; i++) begin
        pix_q[i] <= (32'(band_count_q) > i) ? band[i] : '0;
      end
      for (int i = 0; i < NC; i++) begin
        cls_use_q[i] <= (32'(class_count_q) > i);
      end
    end
  end

  // Stage tokens of the classify word in flight.
  always_comb begin
    vld_d         = vld_q;
    vld_d[0]      = accept && is_classify;
    for (int s = 1; s < NS - 1; s++) begin
      vld_d[s] = vld_q[s-1];
    end
    vld_d[NS-1]   = vld_q[NS-2] || (vld_q[NS-1] && !out_load);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Band multiplier lanes.
  for (genvar b = 0; b < NB; b++) begin : g_mul
    ldc_mul_lane u_mul (
      .clk_i    (clk_i),
      .weight_i (weight_q[b]),
      .pix_i    (pix_q[b]),
      .prod_o   (prod[b])
    );
  end

  // Dot product.
  ldc_sum_tree u_sum (
    .clk_i  (clk_i),
    .prod_i (prod),
    .sum_o  (proj)
  );

  // Class distance lanes.
  for (genvar c = 0; c < NC; c++) begin : g_dist
    ldc_dist_lane u_dist (
      .clk_i    (clk_i),
      .proj_i   (proj),
      .centre_i (centre_q[c]),
      .use_i    (cls_use_q[c]),
      .id_i     (ldc_pkg::CLS_W'(c)),
      .cand_o   (cand[c])
    );
  end

  // The last stage holds while the output register is still full.
  assign out_load  = vld_q[NS-1] && (!out_vld_q || res_o.ready);
  assign stage7_en = !(vld_q[NS-1] && !out_load);

  ldc_min_merge u_merge (
    .clk_i      (clk_i),
    .cand_i     (cand),
    .en_i       (stage7_en),
    .class_id_o (best_id)
  );

  // Projection travels beside the distance and merge stages.
  always_ff @(posedge clk_i) begin
    proj5_q <= proj;
    proj6_q <= proj5_q;
    if (stage7_en) begin
      proj7_q <= proj6_q;
    end
  end

  // Output register.
  assign out_vld_d = out_load || (out_vld_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_id_q   <= best_id;
      out_proj_q <= proj7_q;
    end
  end

  assign res_o.valid           = out_vld_q;
  assign res_o.class_id        = out_id_q;
  assign res_o.projected_value = out_proj_q;

endmodule

### rtl/ldc_checker.sv
module ldc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             pix_valid_i,
  input logic                             pix_ready_i,
  input logic [ldc_pkg::MODE_W-1:0]       pix_mode_i,
  input logic                             res_valid_i,
  input logic                             res_ready_i,
  input logic [ldc_pkg::CLS_W-1:0]        res_class_id_i,
  input logic signed [ldc_pkg::VAL_W-1:0] res_projected_value_i
);

  // A classify word blocks the input while it is in flight.
  a_classify_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_valid_i && pix_ready_i && (pix_mode_i == ldc_pkg::MODE_CLASSIFY)) |=> !pix_ready_i)
    else $error("input ready while a classify word is in flight");

  // With the output register empty, a classify word's result shows up on time.
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_valid_i && pix_ready_i && (pix_mode_i == ldc_pkg::MODE_CLASSIFY) && !res_valid_i)
      |-> ##9 res_valid_i)
    else $error("classify result missing");

  // When a result arrives the pipeline is empty again.
  a_ready_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> pix_ready_i)
    else $error("input not ready after a result was produced");

  // A stalled result word holds.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=>
      (res_valid_i && $stable(res_class_id_i) && $stable(res_projected_value_i)))
    else $error("stalled result word changed");

endmodule

bind linear_discriminant_pixel_classifier_top ldc_checker u_ldc_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .pix_valid_i           (pix_i.valid),
  .pix_ready_i           (pix_i.ready),
  .pix_mode_i            (pix_i.mode),
  .res_valid_i           (res_o.valid),
  .res_ready_i           (res_o.ready),
  .res_class_id_i        (res_o.class_id),
  .res_projected_value_i (res_o.projected_value)
);
